// ===== hw/rtl/uwpe_pkg.sv =====
// shared types, constants and helper functions of the wall pose estimator
`timescale 1ns / 1ps
package uwpe_pkg;

   // iteration counts of the pipelined units
   localparam int CORDIC_STEPS = 21;
   localparam int SQRT_STEPS   = 18;
   localparam int QUO_BITS     = 19;

   // datapath widths
   localparam int ROOT_W = 18;  // rounded hypotenuse
   localparam int RAD_W  = 35;  // sum of squares
   localparam int NUM_W  = 37;  // magnitude of a projected numerator

   // register reset values
   localparam logic [16:0] FPO_RESET  = 17'd2964;
   localparam logic [16:0] SPO_RESET  = 17'd2250;
   localparam logic [15:0] LSP_RESET  = 16'd1727;
   localparam logic [15:0] RSP_RESET  = 16'd1727;
   localparam logic [16:0] SSP_RESET  = 17'd1321;
   localparam logic [16:0] FIELD_RESET = 17'd58522;

   // angles in 2^-16 turn, lengths in 1/16 mm
   localparam logic signed [17:0] QUARTER_TURN = 18'sd16384;
   localparam logic signed [17:0] HEAD_MAX     = 18'sd49152;
   localparam logic signed [17:0] HEAD_MIN     = -18'sd32768;
   localparam logic signed [20:0] POS_MAX      = 21'sd262143;
   localparam logic signed [20:0] POS_MIN      = -21'sd262144;

   typedef enum logic [1:0] {
      FACE_WEST  = 2'd0,
      FACE_NORTH = 2'd1,
      FACE_EAST  = 2'd2,
      FACE_SOUTH = 2'd3
   } facing_type;

   typedef enum logic [2:0] {
      CSR_FRONT_PERP_OFFSET = 3'd0,
      CSR_SIDE_PERP_OFFSET  = 3'd1,
      CSR_LEFT_SPAN         = 3'd2,
      CSR_RIGHT_SPAN        = 3'd3,
      CSR_SIDE_SPAN         = 3'd4,
      CSR_FIELD_SIZE        = 3'd5
   } csr_index_type;

   // per-transaction data that rides alongside the arithmetic units
   typedef struct packed {
      logic signed [17:0] ld;
      logic signed [17:0] sd;
      facing_type         facing;
      logic               zero_h;
      logic               neg_x;
      logic               neg_y;
   } side_type;

   // atan(2^-i) in 2^-24 turn
   function automatic logic [23:0] atan_entry(input int i);
      logic [23:0] v;
      case (i)
         0:  v = 24'd2097152;
         1:  v = 24'd1238021;
         2:  v = 24'd654136;
         3:  v = 24'd332050;
         4:  v = 24'd166669;
         5:  v = 24'd83416;
         6:  v = 24'd41718;
         7:  v = 24'd20860;
         8:  v = 24'd10430;
         9:  v = 24'd5215;
         10: v = 24'd2608;
         11: v = 24'd1304;
         12: v = 24'd652;
         13: v = 24'd326;
         14: v = 24'd163;
         15: v = 24'd81;
         16: v = 24'd41;
         17: v = 24'd20;
         18: v = 24'd10;
         19: v = 24'd5;
         20: v = 24'd3;
         default: v = 24'd0;
      endcase
      return v;
   endfunction

   // saturate a position to 19 bits
   function automatic logic signed [18:0] sat_pos(input logic signed [20:0] v);
      logic signed [18:0] r;
      if (v > POS_MAX) r = 19'(POS_MAX);
      else if (v < POS_MIN) r = 19'(POS_MIN);
      else r = 19'(v);
      return r;
   endfunction

   // clamp a heading to its output range
   function automatic logic signed [16:0] clamp_head(input logic signed [17:0] v);
      logic signed [16:0] r;
      if (v > HEAD_MAX) r = 17'(HEAD_MAX);
      else if (v < HEAD_MIN) r = 17'(HEAD_MIN);
      else r = 17'(v);
      return r;
   endfunction

endpackage

// ===== hw/rtl/uwpe_div.sv =====
// pipelined restoring divider with round-half-up, one quotient bit per stage
`timescale 1ns / 1ps
module uwpe_div import uwpe_pkg::*; (
   input  logic                clock,
   input  logic                adv,
   input  logic [NUM_W-1:0]    num,
   input  logic [ROOT_W-1:0]   den,
   output logic [QUO_BITS-1:0] quo
);

   localparam int REM_W = NUM_W + 1;

   logic [REM_W-1:0]    rm_ff  [0:QUO_BITS];
   logic [ROOT_W-1:0]   den_ff [0:QUO_BITS];
   logic [QUO_BITS-1:0] qb_ff  [1:QUO_BITS];
   logic [REM_W-1:0]    rm0_in;

   // add half the divisor for rounding
   assign rm0_in = REM_W'(num) + REM_W'(den >> 1);

   always_ff @(posedge clock) begin
      if (adv) begin
         rm_ff[0]  <= rm0_in;
         den_ff[0] <= den;
      end
   end

   // one compare and subtract per stage
   genvar i;
   for (i = 1; i <= QUO_BITS; i++) begin : g_step
      localparam int B = QUO_BITS - i;
      logic [REM_W-1:0]    trial;
      logic [QUO_BITS-1:0] q_src;
      logic [REM_W-1:0]    rm_in;
      logic [QUO_BITS-1:0] qb_in;

      if (i == 1) begin : g_first
         assign q_src = '0;
      end else begin : g_next
         assign q_src = qb_ff[i-1];
      end

      assign trial = REM_W'(den_ff[i-1]) << B;

      always_comb begin
         if (rm_ff[i-1] >= trial) begin
            rm_in = rm_ff[i-1] - trial;
            qb_in = q_src | (QUO_BITS'(1) << B);
         end else begin
            rm_in = rm_ff[i-1];
            qb_in = q_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rm_ff[i]  <= rm_in;
            den_ff[i] <= den_ff[i-1];
            qb_ff[i]  <= qb_in;
         end
      end
   end

   assign quo = qb_ff[QUO_BITS];

endmodule

// ===== hw/rtl/uwpe_cordic.sv =====
// pipelined vectoring cordic, one rotation per stage, angle in 2^-16 turn
`timescale 1ns / 1ps
module uwpe_cordic import uwpe_pkg::*; (
   input  logic               clock,
   input  logic               adv,
   input  logic [16:0]        span_sum,
   input  logic signed [16:0] span_diff,
   output logic signed [16:0] theta
);

   logic signed [31:0] cx_ff [0:CORDIC_STEPS-1];
   logic signed [31:0] cy_ff [0:CORDIC_STEPS-1];
   logic signed [24:0] cz_ff [0:CORDIC_STEPS-1];
   logic signed [16:0] theta_ff;
   logic signed [24:0] zr_in;
   logic signed [16:0] theta_in;

   genvar i;
   for (i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      logic signed [31:0] x_src, y_src, xs, ys, x_in, y_in;
      logic signed [24:0] z_src, z_in, ang;

      // inputs prescaled by 2^12
      if (i == 0) begin : g_first
         assign x_src = $signed({3'b000, span_sum, 12'h000});
         assign y_src = $signed({{3{span_diff[16]}}, span_diff, 12'h000});
         assign z_src = '0;
      end else begin : g_next
         assign x_src = cx_ff[i-1];
         assign y_src = cy_ff[i-1];
         assign z_src = cz_ff[i-1];
      end

      assign xs  = x_src >>> i;
      assign ys  = y_src >>> i;
      assign ang = $signed({1'b0, atan_entry(i)});

      // rotate toward the x axis
      always_comb begin
         if (!y_src[31]) begin
            x_in = x_src + ys;
            y_in = y_src - xs;
            z_in = z_src + ang;
         end else begin
            x_in = x_src - ys;
            y_in = y_src + xs;
            z_in = z_src - ang;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cx_ff[i] <= x_in;
            cy_ff[i] <= y_in;
            cz_ff[i] <= z_in;
         end
      end
   end

   // round 2^-24 turn down to 2^-16 turn
   assign zr_in    = (cz_ff[CORDIC_STEPS-1] + 25'sd128) >>> 8;
   assign theta_in = 17'(zr_in);

   always_ff @(posedge clock) begin
      if (adv) theta_ff <= theta_in;
   end

   assign theta = theta_ff;

endmodule

// ===== hw/rtl/ultrasonic_wall_pose_estimator_unit.sv =====
// top level of the wall pose estimator: offsets, products, root, divides, angle, mapping
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | left, right, side readings, facing
//   rsp     | out       | rsp_valid/rsp_stall | pos_x, pos_y, heading
//   csr     | in        | csr_wr_en           | csr_index, csr_wdata
//
// one transaction enters per cycle while the output is not stalled; the pipeline runs through
// the 18-stage square root and then the divider (the cordic runs beside them).
// synchronous reset clears valid bits and loads register defaults.
// a stalled result freezes the whole pipeline, and req_stall follows it.
`timescale 1ns / 1ps
module ultrasonic_wall_pose_estimator_unit import uwpe_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [11:0]        req_left_reading,
   input  logic [11:0]        req_right_reading,
   input  logic [11:0]        req_side_reading,
   input  logic [1:0]         req_facing,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [18:0] rsp_pos_x,
   output logic signed [18:0] rsp_pos_y,
   output logic signed [16:0] rsp_heading,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [16:0]        csr_wdata
);

   localparam int P_H   = 3 + SQRT_STEPS + 1;
   localparam int P_Q   = P_H + QUO_BITS + 1;
   localparam int P_TH  = 1 + CORDIC_STEPS + 1;

   // configuration registers
   logic signed [16:0] fpo_ff, spo_ff, ssp_ff;
   logic [15:0]        lsp_ff, rsp_ff;
   logic [16:0]        fs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fpo_ff <= FPO_RESET;
         spo_ff <= SPO_RESET;
         lsp_ff <= LSP_RESET;
         rsp_ff <= RSP_RESET;
         ssp_ff <= SSP_RESET;
         fs_ff  <= FIELD_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FRONT_PERP_OFFSET: fpo_ff <= csr_wdata;
            CSR_SIDE_PERP_OFFSET:  spo_ff <= csr_wdata;
            CSR_LEFT_SPAN:         lsp_ff <= csr_wdata[15:0];
            CSR_RIGHT_SPAN:        rsp_ff <= csr_wdata[15:0];
            CSR_SIDE_SPAN:         ssp_ff <= csr_wdata;
            CSR_FIELD_SIZE:        fs_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline advance and valid bits
   logic           adv, accept;
   logic           v_ff [1:P_Q];
   logic           rsp_valid_ff;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign accept    = req_valid && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 1; j <= P_Q; j++) v_ff[j] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v_ff[1] <= accept;
         for (int j = 2; j <= P_Q; j++) v_ff[j] <= v_ff[j-1];
         rsp_valid_ff <= v_ff[P_Q];
      end
   end

   // stage 1: scaled distances, span sum and difference
   logic signed [17:0] ld1_in, sd1_in, ld1_ff, sd1_ff;
   logic [16:0]        s1_in, s1_ff;
   logic signed [12:0] diff13;
   logic signed [16:0] d1_in, d1_ff;
   facing_type         face1_ff;

   assign ld1_in = $signed({2'b00, req_left_reading, 4'h0}) + $signed({fpo_ff[16], fpo_ff});
   assign sd1_in = $signed({2'b00, req_side_reading, 4'h0}) + $signed({spo_ff[16], spo_ff});
   assign s1_in  = {1'b0, lsp_ff} + {1'b0, rsp_ff};
   assign diff13 = $signed({1'b0, req_right_reading}) - $signed({1'b0, req_left_reading});
   assign d1_in  = $signed({diff13, 4'h0});

   always_ff @(posedge clock) begin
      if (adv) begin
         ld1_ff   <= ld1_in;
         sd1_ff   <= sd1_in;
         s1_ff    <= s1_in;
         d1_ff    <= d1_in;
         face1_ff <= facing_type'(req_facing);
      end
   end

   // stage 2: products
   logic [33:0]        ss2_in, ss2_ff;
   logic signed [33:0] dd2_in, dd2_ff, lxd2_in, lxd2_ff, syd2_in, syd2_ff;
   logic signed [35:0] lxs2_in, lxs2_ff, sys2_in, sys2_ff;
   logic signed [17:0] s1_signed;
   logic signed [17:0] ld2_ff, sd2_ff;
   facing_type         face2_ff;
   logic               zero2_in, zero2_ff;

   assign s1_signed = $signed({1'b0, s1_ff});
   assign ss2_in    = 34'(s1_ff) * 34'(s1_ff);
   assign dd2_in    = 34'(d1_ff) * 34'(d1_ff);
   assign lxs2_in   = 36'(ld1_ff) * 36'(s1_signed);
   assign sys2_in   = 36'(sd1_ff) * 36'(s1_signed);
   assign lxd2_in   = 34'($signed({1'b0, lsp_ff})) * 34'(d1_ff);
   assign syd2_in   = 34'(ssp_ff) * 34'(d1_ff);
   assign zero2_in  = (s1_ff == '0) && (d1_ff == '0);

   always_ff @(posedge clock) begin
      if (adv) begin
         ss2_ff   <= ss2_in;
         dd2_ff   <= dd2_in;
         lxs2_ff  <= lxs2_in;
         sys2_ff  <= sys2_in;
         lxd2_ff  <= lxd2_in;
         syd2_ff  <= syd2_in;
         ld2_ff   <= ld1_ff;
         sd2_ff   <= sd1_ff;
         face2_ff <= face1_ff;
         zero2_ff <= zero2_in;
      end
   end

   // stage 3: sum of squares and numerator magnitudes
   logic [RAD_W-1:0]   q3_in, q3_ff;
   logic signed [NUM_W-1:0] nx3, ny3;
   logic [NUM_W-1:0]   ax3_in, ay3_in, ax3_ff, ay3_ff;
   side_type           side3_in, side3_ff;

   assign q3_in  = {1'b0, ss2_ff} + {2'b00, dd2_ff[32:0]};
   assign nx3    = NUM_W'(lxs2_ff) - NUM_W'(lxd2_ff);
   assign ny3    = NUM_W'(sys2_ff) - NUM_W'(syd2_ff);
   assign ax3_in = nx3[NUM_W-1] ? NUM_W'(-nx3) : NUM_W'(nx3);
   assign ay3_in = ny3[NUM_W-1] ? NUM_W'(-ny3) : NUM_W'(ny3);

   always_comb begin
      side3_in.ld     = ld2_ff;
      side3_in.sd     = sd2_ff;
      side3_in.facing = face2_ff;
      side3_in.zero_h = zero2_ff;
      side3_in.neg_x  = nx3[NUM_W-1];
      side3_in.neg_y  = ny3[NUM_W-1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q3_ff    <= q3_in;
         ax3_ff   <= ax3_in;
         ay3_ff   <= ay3_in;
         side3_ff <= side3_in;
      end
   end

   // square root, one root bit per stage
   logic [ROOT_W-1:0] rt_ff [0:SQRT_STEPS-1];
   logic [RAD_W-1:0]  rm_ff [0:SQRT_STEPS-1];
   logic [NUM_W-1:0]  axs_ff [0:SQRT_STEPS-1];
   logic [NUM_W-1:0]  ays_ff [0:SQRT_STEPS-1];

   genvar k;
   for (k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam int B = SQRT_STEPS - 1 - k;
      logic [ROOT_W-1:0]  r_src, r_in;
      logic [RAD_W-1:0]   m_src, m_in;
      logic [NUM_W-1:0]   ax_src, ay_src;
      logic [RAD_W+2:0]   trial, m_wide;

      if (k == 0) begin : g_first
         assign r_src  = '0;
         assign m_src  = q3_ff;
         assign ax_src = ax3_ff;
         assign ay_src = ay3_ff;
      end else begin : g_next
         assign r_src  = rt_ff[k-1];
         assign m_src  = rm_ff[k-1];
         assign ax_src = axs_ff[k-1];
         assign ay_src = ays_ff[k-1];
      end

      assign trial  = ((RAD_W+3)'(r_src) << (B + 1)) + ((RAD_W+3)'(1) << (2 * B));
      assign m_wide = (RAD_W+3)'(m_src);

      always_comb begin
         if (m_wide >= trial) begin
            m_in = RAD_W'(m_wide - trial);
            r_in = r_src | (ROOT_W'(1) << B);
         end else begin
            m_in = m_src;
            r_in = r_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rt_ff[k]  <= r_in;
            rm_ff[k]  <= m_in;
            axs_ff[k] <= ax_src;
            ays_ff[k] <= ay_src;
         end
      end
   end

   // round the root to nearest
   logic [ROOT_W-1:0] h_in, h_ff;
   logic [NUM_W-1:0]  axh_ff, ayh_ff;

   assign h_in = (rm_ff[SQRT_STEPS-1] > RAD_W'(rt_ff[SQRT_STEPS-1]))
                 ? rt_ff[SQRT_STEPS-1] + ROOT_W'(1) : rt_ff[SQRT_STEPS-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         h_ff   <= h_in;
         axh_ff <= axs_ff[SQRT_STEPS-1];
         ayh_ff <= ays_ff[SQRT_STEPS-1];
      end
   end

   // projected wall distances
   logic [QUO_BITS-1:0] qx, qy;

   uwpe_div u_div_x (
      .clock (clock),
      .adv   (adv),
      .num   (axh_ff),
      .den   (h_ff),
      .quo   (qx)
   );

   uwpe_div u_div_y (
      .clock (clock),
      .adv   (adv),
      .num   (ayh_ff),
      .den   (h_ff),
      .quo   (qy)
   );

   // heading angle
   logic signed [16:0] theta;

   uwpe_cordic u_cordic (
      .clock     (clock),
      .adv       (adv),
      .span_sum  (s1_ff),
      .span_diff (d1_ff),
      .theta     (theta)
   );

   // alignment delay lines
   side_type           side_dl_ff [4:P_Q];
   logic signed [16:0] th_dl_ff   [P_TH+1:P_Q];

   always_ff @(posedge clock) begin
      if (adv) begin
         side_dl_ff[4] <= side3_ff;
         for (int j = 5; j <= P_Q; j++) side_dl_ff[j] <= side_dl_ff[j-1];
         th_dl_ff[P_TH+1] <= theta;
         for (int j = P_TH + 2; j <= P_Q; j++) th_dl_ff[j] <= th_dl_ff[j-1];
      end
   end

   // output stage: sign, special case, field mapping, saturation
   side_type           so;
   logic signed [19:0] x0, y0;
   logic signed [16:0] th;
   logic signed [20:0] fsz, px, py;
   logic signed [17:0] hd;
   logic signed [18:0] pos_x_in, pos_y_in, pos_x_ff, pos_y_ff;
   logic signed [16:0] head_in, head_ff;

   assign so  = side_dl_ff[P_Q];
   assign fsz = $signed({4'h0, fs_ff});

   always_comb begin
      if (so.zero_h) begin
         x0 = 20'(so.ld);
         y0 = 20'(so.sd);
         th = '0;
      end else begin
         x0 = so.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
         y0 = so.neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
         th = th_dl_ff[P_Q];
      end
   end

   always_comb begin
      case (so.facing)
         FACE_WEST: begin
            px = 21'(x0);
            py = 21'(y0);
            hd = 18'(th);
         end
         FACE_NORTH: begin
            px = fsz - 21'(y0);
            py = 21'(x0);
            hd = 18'(th) + QUARTER_TURN;
         end
         FACE_EAST: begin
            px = fsz - 21'(x0);
            py = fsz - 21'(y0);
            hd = 18'(th) + (QUARTER_TURN <<< 1);
         end
         default: begin
            px = 21'(y0);
            py = fsz - 21'(x0);
            hd = 18'(th) - QUARTER_TURN;
         end
      endcase
      pos_x_in = sat_pos(px);
      pos_y_in = sat_pos(py);
      head_in  = clamp_head(hd);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         head_ff  <= head_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pos_x   = pos_x_ff;
   assign rsp_pos_y   = pos_y_ff;
   assign rsp_heading = head_ff;

endmodule

// ===== hw/rtl/uwpe_checker.sv =====
// port-level checks on the wall pose estimator, bound to the top level
`timescale 1ns / 1ps
module uwpe_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [18:0] rsp_pos_x,
   input logic signed [18:0] rsp_pos_y,
   input logic signed [16:0] rsp_heading
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // input is held back exactly when a result is blocked
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow output backpressure");

   // a blocked result stays and holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y)
      && $stable(rsp_heading))
      else $error("blocked result changed");

   // heading stays within its clamped range
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_heading <= 17'sd49152) && (rsp_heading >= -17'sd32768))
      else $error("heading out of range");

endmodule

bind ultrasonic_wall_pose_estimator_unit uwpe_checker u_uwpe_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_pos_x   (rsp_pos_x),
   .rsp_pos_y   (rsp_pos_y),
   .rsp_heading (rsp_heading)
);
